// ===== rtl/goal_velocity_vector_macros.svh =====
// assertion macros shared by the goal velocity vector rtl
`ifndef GOAL_VELOCITY_VECTOR_MACROS_SVH
`define GOAL_VELOCITY_VECTOR_MACROS_SVH

// same-cycle implication, masked during reset
`define GVV_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("goal velocity vector check failed");

// next-cycle implication, masked during reset
`define GVV_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("goal velocity vector check failed");

`endif

// ===== rtl/gvv_pkg.sv =====
// shared types and constants of the goal velocity vector block
package gvv_pkg;

  // fixed field widths
  localparam int VEL_W     = 16;
  localparam int CFG_W     = 16;
  localparam int NORM_W    = 31;
  localparam int ROOT_IN_W = 64;
  localparam int ROOT_W    = 32;
  localparam int QUO_W     = 16;
  localparam int SINE_LAT  = 7;

  // unit length in q1.14
  localparam logic [15:0] UNIT_ONE = 16'd16384;

  // register indexes on the config port
  typedef enum logic [0:0] {
    REG_DEAD_ZONE    = 1'b0,
    REG_CONTROL_ZONE = 1'b1
  } gvv_reg_t;

  // per-word side flags
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic dead;
    logic ramp;
  } gvv_flags_t;

  // taylor coefficients of sin(pi/2 x)/x, q30
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172272;

endpackage

// ===== rtl/gvv_front.sv =====
// bias, zone tests, normalisation and squared norm of the direction
module gvv_front #(
  parameter int POS_WIDTH = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [POS_WIDTH-1:0] pose_x,
  input  logic signed [POS_WIDTH-1:0] pose_y,
  input  logic signed [POS_WIDTH-1:0] goal_x,
  input  logic signed [POS_WIDTH-1:0] goal_y,
  input  logic signed [POS_WIDTH-1:0] offset_x,
  input  logic signed [POS_WIDTH-1:0] offset_y,
  input  logic [31:0]                 dz_sq,
  input  logic [31:0]                 cz_sq,
  output logic [63:0]                 n2,
  output logic [63:0]                 sq20,
  output logic [30:0]                 nx,
  output logic [30:0]                 ny,
  output gvv_pkg::gvv_flags_t         flags
);

  localparam int BW    = POS_WIDTH + 2;
  localparam int AW    = POS_WIDTH + 1;
  localparam int CW    = (AW < 31) ? AW : 31;
  localparam int CW2   = 2 * CW;
  localparam int SQW   = CW2 + 1;
  localparam int NSTEP = $clog2(AW);
  localparam int DLY   = NSTEP - 3;
  localparam int NSW   = 3 * AW;
  localparam logic [63:0] LIM_Q = ((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd10000;

  // one leading-zero step: shift left by sh when the top sh bits are clear
  function automatic logic [NSW-1:0] nrm_step(logic [NSW-1:0] s, int unsigned sh);
    logic [AW-1:0] m;
    logic [AW-1:0] x;
    logic [AW-1:0] y;
    m = s[NSW-1 -: AW];
    x = s[2*AW-1 -: AW];
    y = s[AW-1:0];
    if ((m >> (AW - sh)) == '0) begin
      m = m << sh;
      x = x << sh;
      y = y << sh;
    end
    return {m, x, y};
  endfunction

  logic signed [BW-1:0] bx, by;
  logic [AW-1:0] ax, ay, amax;
  logic          neg_x, neg_y, big;
  logic [AW-1:0] ax_next, ay_next;

  // bias sum
  always_ff @(posedge clk) begin
    if (en) begin
      bx <= BW'(goal_x) - BW'(pose_x) + BW'(offset_x);
      by <= BW'(goal_y) - BW'(pose_y) + BW'(offset_y);
    end
  end

  // magnitudes, larger one and range check
  always_comb begin
    ax_next = bx[BW-1] ? AW'(-bx) : AW'(bx);
    ay_next = by[BW-1] ? AW'(-by) : AW'(by);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax    <= ax_next;
      ay    <= ay_next;
      amax  <= (ax_next > ay_next) ? ax_next : ay_next;
      neg_x <= bx[BW-1];
      neg_y <= by[BW-1];
      big   <= ((((ax_next > ay_next) ? ax_next : ay_next) >> 31) != '0);
    end
  end

  // normalisation chain, one shift step per stage
  logic [NSW-1:0] nrm      [NSTEP];
  logic [NSW-1:0] nrm_next [NSTEP];

  always_comb begin
    nrm_next[0] = nrm_step({amax, ax, ay}, 32'(1) << (NSTEP - 1));
    for (int k = 1; k < NSTEP; k++) begin
      nrm_next[k] = nrm_step(nrm[k-1], 32'(1) << (NSTEP - 1 - k));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm <= nrm_next;
    end
  end

  // squared length alongside: products, sum, zone compares
  logic [CW2-1:0] ax2, ay2;
  logic           big_a, big_b, negx_a, negy_a, negx_b, negy_b;
  logic [SQW-1:0] sq_b;
  gvv_pkg::gvv_flags_t fl_c;
  logic [63:0]    sq20_c;
  logic           dead_c;

  always_ff @(posedge clk) begin
    if (en) begin
      ax2    <= CW2'(CW'(ax)) * CW2'(CW'(ax));
      ay2    <= CW2'(CW'(ay)) * CW2'(CW'(ay));
      big_a  <= big;
      negx_a <= neg_x;
      negy_a <= neg_y;
      sq_b   <= SQW'(ax2) + SQW'(ay2);
      big_b  <= big_a;
      negx_b <= negx_a;
      negy_b <= negy_a;
    end
  end

  assign dead_c = !big_b && ((64'(sq_b) < 64'(dz_sq)) || (64'(sq_b) <= LIM_Q));

  always_ff @(posedge clk) begin
    if (en) begin
      fl_c.neg_x <= negx_b;
      fl_c.neg_y <= negy_b;
      fl_c.dead  <= dead_c;
      fl_c.ramp  <= !big_b && !dead_c && (64'(sq_b) < 64'(cz_sq));
      sq20_c     <= 64'(sq_b) << 20;
    end
  end

  // match the flags to the normalisation depth
  gvv_pkg::gvv_flags_t fl_d   [DLY];
  logic [63:0]         sq20_d [DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      fl_d[0]   <= fl_c;
      sq20_d[0] <= sq20_c;
      for (int i = 1; i < DLY; i++) begin
        fl_d[i]   <= fl_d[i-1];
        sq20_d[i] <= sq20_d[i-1];
      end
    end
  end

  // bring the larger magnitude into [2^30, 2^31)
  logic [AW-1:0] jx, jy;
  logic [30:0]   nx_w, ny_w;

  assign jx = nrm[NSTEP-1][2*AW-1 -: AW];
  assign jy = nrm[NSTEP-1][AW-1:0];

  generate
    if (AW >= 31) begin : g_narrow
      assign nx_w = 31'(jx >> (AW - 31));
      assign ny_w = 31'(jy >> (AW - 31));
    end else begin : g_widen
      assign nx_w = 31'(jx) << (31 - AW);
      assign ny_w = 31'(jy) << (31 - AW);
    end
  endgenerate

  // squares of the normalised components, then their sum
  logic [61:0] px2, py2;
  logic [30:0] nx_f, ny_f;
  gvv_pkg::gvv_flags_t fl_f;
  logic [63:0] sq20_f;

  always_ff @(posedge clk) begin
    if (en) begin
      px2    <= 62'(nx_w) * 62'(nx_w);
      py2    <= 62'(ny_w) * 62'(ny_w);
      nx_f   <= nx_w;
      ny_f   <= ny_w;
      fl_f   <= fl_d[DLY-1];
      sq20_f <= sq20_d[DLY-1];
      n2     <= 64'(px2) + 64'(py2);
      nx     <= nx_f;
      ny     <= ny_f;
      flags  <= fl_f;
      sq20   <= sq20_f;
    end
  end

endmodule

// ===== rtl/gvv_isqrt.sv =====
// pipelined digit-by-digit integer square root, one root bit per stage
module gvv_isqrt #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 4
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   din,
  input  logic [SIDE_W-1:0] side_in,
  output logic [IN_W/2-1:0] root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int RW = IN_W / 2;
  localparam int EW = RW + 2;
  localparam int SW = IN_W + EW + RW;

  // bring down two radicand bits, try (root << 2) | 1
  function automatic logic [SW-1:0] sq_step(logic [SW-1:0] s);
    logic [IN_W-1:0] x;
    logic [EW-1:0]   rem;
    logic [EW-1:0]   rsh;
    logic [EW-1:0]   trial;
    logic [RW-1:0]   r;
    x     = s[SW-1 -: IN_W];
    rem   = s[RW +: EW];
    r     = s[RW-1:0];
    rsh   = {rem[RW-1:0], x[IN_W-1 -: 2]};
    trial = {r, 2'b01};
    if (rsh >= trial) begin
      rem = rsh - trial;
      r   = {r[RW-2:0], 1'b1};
    end else begin
      rem = rsh;
      r   = {r[RW-2:0], 1'b0};
    end
    x = x << 2;
    return {x, rem, r};
  endfunction

  logic [SW-1:0]     st      [RW];
  logic [SW-1:0]     st_next [RW];
  logic [SIDE_W-1:0] side_s  [RW];

  always_comb begin
    st_next[0] = sq_step({din, EW'(0), RW'(0)});
    for (int k = 1; k < RW; k++) begin
      st_next[k] = sq_step(st[k-1]);
    end
  end

  // stage registers and side data
  always_ff @(posedge clk) begin
    if (en) begin
      st        <= st_next;
      side_s[0] <= side_in;
      for (int k = 1; k < RW; k++) begin
        side_s[k] <= side_s[k-1];
      end
    end
  end

  assign root     = st[RW-1][RW-1:0];
  assign side_out = side_s[RW-1];

endmodule

// ===== rtl/gvv_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module gvv_div #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 32,
  parameter int Q_W   = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  localparam int WW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
  localparam int SW = NUM_W + DEN_W + Q_W;

  // subtract den << sh when it fits
  function automatic logic [SW-1:0] div_step(logic [SW-1:0] s, int unsigned sh);
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] d;
    logic [Q_W-1:0]   q;
    logic [WW-1:0]    dsh;
    logic             qbit;
    rem  = s[SW-1 -: NUM_W];
    d    = s[Q_W +: DEN_W];
    q    = s[Q_W-1:0];
    dsh  = WW'(d) << sh;
    qbit = (WW'(rem) >= dsh);
    if (qbit) begin
      rem = NUM_W'(WW'(rem) - dsh);
    end
    q = {q[Q_W-2:0], qbit};
    return {rem, d, q};
  endfunction

  logic [SW-1:0] st      [Q_W];
  logic [SW-1:0] st_next [Q_W];

  always_comb begin
    st_next[0] = div_step({num, den, Q_W'(0)}, Q_W - 1);
    for (int k = 1; k < Q_W; k++) begin
      st_next[k] = div_step(st[k-1], Q_W - 1 - k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= st_next;
    end
  end

  assign quo = st[Q_W-1][Q_W-1:0];

endmodule

// ===== rtl/gvv_sine.sv =====
// sine ramp polynomial, scaling and sign of the velocity
module gvv_sine (
  input  logic                clk,
  input  logic                en,
  input  logic [15:0]         t,
  input  logic [15:0]         qx,
  input  logic [15:0]         qy,
  input  gvv_pkg::gvv_flags_t flags_in,
  output logic signed [15:0]  vel_x,
  output logic signed [15:0]  vel_y,
  output logic                dead,
  output logic                ramp
);

  localparam logic [46:0] ROUND = 47'd1 << 29;

  logic [29:0] x2_1, x2_2, x2_3, x2_4;
  logic [15:0] t1, t2, t3, t4, t5;
  logic [14:0] mx1, mx2, mx3, mx4, mx5, mx6;
  logic [14:0] my1, my2, my3, my4, my5, my6;
  gvv_pkg::gvv_flags_t fl1, fl2, fl3, fl4, fl5, fl6;
  logic [30:0] p7, p5, p3, p1, s6;
  logic [14:0] mag_x, mag_y;

  // x^2 in q30 is t*t/4, magnitudes clamped to one
  always_ff @(posedge clk) begin
    if (en) begin
      x2_1 <= 30'((32'(t) * 32'(t)) >> 2);
      t1   <= t;
      mx1  <= (qx > gvv_pkg::UNIT_ONE) ? 15'(gvv_pkg::UNIT_ONE) : qx[14:0];
      my1  <= (qy > gvv_pkg::UNIT_ONE) ? 15'(gvv_pkg::UNIT_ONE) : qy[14:0];
      fl1  <= flags_in;
    end
  end

  // horner steps, one product per stage
  always_ff @(posedge clk) begin
    if (en) begin
      p7   <= gvv_pkg::SIN_C7 - 31'((61'(x2_1) * 61'(gvv_pkg::SIN_C9)) >> 30);
      x2_2 <= x2_1;
      t2   <= t1;
      mx2  <= mx1;
      my2  <= my1;
      fl2  <= fl1;
      p5   <= gvv_pkg::SIN_C5 - 31'((61'(x2_2) * 61'(p7)) >> 30);
      x2_3 <= x2_2;
      t3   <= t2;
      mx3  <= mx2;
      my3  <= my2;
      fl3  <= fl2;
      p3   <= gvv_pkg::SIN_C3 - 31'((61'(x2_3) * 61'(p5)) >> 30);
      x2_4 <= x2_3;
      t4   <= t3;
      mx4  <= mx3;
      my4  <= my3;
      fl4  <= fl3;
      p1   <= gvv_pkg::SIN_C1 - 31'((61'(x2_4) * 61'(p3)) >> 30);
      t5   <= t4;
      mx5  <= mx4;
      my5  <= my4;
      fl5  <= fl4;
    end
  end

  // final product x * p gives the sine in q30
  always_ff @(posedge clk) begin
    if (en) begin
      s6  <= 31'((47'(t5) * 47'(p1)) >> 16);
      mx6 <= mx5;
      my6 <= my5;
      fl6 <= fl5;
    end
  end

  // rounded scaling inside the ramp
  always_comb begin
    mag_x = fl6.ramp ? 15'((47'(mx6) * 47'(s6) + ROUND) >> 30) : mx6;
    mag_y = fl6.ramp ? 15'((47'(my6) * 47'(s6) + ROUND) >> 30) : my6;
  end

  // sign and dead-zone zeroing
  always_ff @(posedge clk) begin
    if (en) begin
      vel_x <= fl6.dead ? '0 : (fl6.neg_x ? -$signed(16'(mag_x)) : $signed(16'(mag_x)));
      vel_y <= fl6.dead ? '0 : (fl6.neg_y ? -$signed(16'(mag_y)) : $signed(16'(mag_y)));
      dead  <= fl6.dead;
      ramp  <= fl6.ramp;
    end
  end

endmodule

// ===== rtl/goal_velocity_vector.sv =====
// Throughput: one word per cycle; the two 32-stage square roots and the 16-stage
// dividers set the depth, each stage resolving one bit.
// The whole pipeline holds while a result waits at the output and is not taken.
// Reset (synchronous) empties the pipeline and sets dead_zone to 26 and
// control_zone to 256.
`include "goal_velocity_vector_macros.svh"

module goal_velocity_vector #(
  parameter int POS_WIDTH = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // pose_x, pose_y, goal_x, goal_y, offset_x, offset_y, zero fill
  input  logic [((6*POS_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // vel_x, vel_y
  output logic [31:0]                        m_tdata,
  // in_dead_zone, in_ramp_zone
  output logic [1:0]                         m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [0:0]                         cfg_index,
  input  logic [gvv_pkg::CFG_W-1:0]          cfg_data
);

  localparam int PW        = POS_WIDTH;
  localparam int FRONT_LAT = $clog2(POS_WIDTH + 1) + 4;
  localparam int LAT       = FRONT_LAT + gvv_pkg::ROOT_W + gvv_pkg::QUO_W + gvv_pkg::SINE_LAT;

  logic en;
  logic [LAT-1:0] vld;

  // configuration registers and their squares
  logic [gvv_pkg::CFG_W-1:0] dead_zone, control_zone;
  logic [31:0] dz_sq, cz_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone    <= 16'd26;
      control_zone <= 16'd256;
    end else if (cfg_valid) begin
      unique case (gvv_pkg::gvv_reg_t'(cfg_index))
        gvv_pkg::REG_DEAD_ZONE:    dead_zone    <= cfg_data;
        gvv_pkg::REG_CONTROL_ZONE: control_zone <= cfg_data;
        default:                   dead_zone    <= dead_zone;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dz_sq <= 32'(dead_zone) * 32'(dead_zone);
    cz_sq <= 32'(control_zone) * 32'(control_zone);
  end

  // pipeline advances unless the output word is held
  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // front end
  logic [63:0] n2, sq20;
  logic [30:0] nx, ny;
  gvv_pkg::gvv_flags_t flags;

  gvv_front #(
    .POS_WIDTH (POS_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .en       (en),
    .pose_x   ($signed(s_tdata[PW-1:0])),
    .pose_y   ($signed(s_tdata[2*PW-1 -: PW])),
    .goal_x   ($signed(s_tdata[3*PW-1 -: PW])),
    .goal_y   ($signed(s_tdata[4*PW-1 -: PW])),
    .offset_x ($signed(s_tdata[5*PW-1 -: PW])),
    .offset_y ($signed(s_tdata[6*PW-1 -: PW])),
    .dz_sq    (dz_sq),
    .cz_sq    (cz_sq),
    .n2       (n2),
    .sq20     (sq20),
    .nx       (nx),
    .ny       (ny),
    .flags    (flags)
  );

  // length of the normalised direction and of the bias in q.10
  logic [gvv_pkg::ROOT_W-1:0] len, lq;
  logic [61:0] nxy_r;
  logic [3:0]  fl_r;

  gvv_isqrt #(
    .IN_W   (gvv_pkg::ROOT_IN_W),
    .SIDE_W (62)
  ) u_root_dir (
    .clk      (clk),
    .en       (en),
    .din      (n2),
    .side_in  ({nx, ny}),
    .root     (len),
    .side_out (nxy_r)
  );

  gvv_isqrt #(
    .IN_W   (gvv_pkg::ROOT_IN_W),
    .SIDE_W (4)
  ) u_root_ramp (
    .clk      (clk),
    .en       (en),
    .din      (sq20),
    .side_in  (flags),
    .root     (lq),
    .side_out (fl_r)
  );

  // unit components and ramp ratio
  logic [45:0] num_x, num_y;
  logic [gvv_pkg::QUO_W-1:0] qx, qy, qt;

  assign num_x = 46'({nxy_r[61:31], 14'b0}) + 46'(len >> 1);
  assign num_y = 46'({nxy_r[30:0], 14'b0}) + 46'(len >> 1);

  gvv_div #(.NUM_W(46), .DEN_W(32), .Q_W(gvv_pkg::QUO_W)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (num_x),
    .den (len),
    .quo (qx)
  );

  gvv_div #(.NUM_W(46), .DEN_W(32), .Q_W(gvv_pkg::QUO_W)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (num_y),
    .den (len),
    .quo (qy)
  );

  gvv_div #(.NUM_W(32), .DEN_W(16), .Q_W(gvv_pkg::QUO_W)) u_div_t (
    .clk (clk),
    .en  (en),
    .num ({lq[25:0], 6'b0}),
    .den (control_zone),
    .quo (qt)
  );

  // flags ride beside the dividers
  gvv_pkg::gvv_flags_t fl_q [gvv_pkg::QUO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      fl_q[0] <= gvv_pkg::gvv_flags_t'(fl_r);
      for (int i = 1; i < gvv_pkg::QUO_W; i++) begin
        fl_q[i] <= fl_q[i-1];
      end
    end
  end

  // sine ramp and output word
  logic signed [gvv_pkg::VEL_W-1:0] vel_x, vel_y;
  logic dead_o, ramp_o;

  gvv_sine u_sine (
    .clk      (clk),
    .en       (en),
    .t        (qt),
    .qx       (qx),
    .qy       (qy),
    .flags_in (fl_q[gvv_pkg::QUO_W-1]),
    .vel_x    (vel_x),
    .vel_y    (vel_y),
    .dead     (dead_o),
    .ramp     (ramp_o)
  );

  assign m_tdata = {vel_y, vel_x};
  assign m_tuser = {ramp_o, dead_o};

  // checks
  `GVV_ASSERT_IMPLY(a_dead_zero_vel, clk, rst, m_tvalid && m_tuser[0], m_tdata == 32'd0)
  `GVV_ASSERT_IMPLY(a_zone_excl, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[1]))
  `GVV_ASSERT_IMPLY(a_vel_x_range, clk, rst, m_tvalid, ($signed(m_tdata[15:0]) >= -16'sd16384) && ($signed(m_tdata[15:0]) <= 16'sd16384))
  `GVV_ASSERT_IMPLY(a_stall_blocks, clk, rst, m_tvalid && !m_tready, !s_tready)

endmodule

// ===== sim/goal_velocity_vector_test.sv =====
// self-checking testbench of the goal velocity vector block
`timescale 1ns / 100ps

module goal_velocity_vector_test;

  // one input word: positions and offset, signed q8.8
  typedef struct {
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
  } pose_word_t;

  // one result word
  typedef struct {
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic        dead;
    logic        ramp;
  } velocity_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  gvv_pkg::gvv_reg_t cfg_index;
  logic [15:0] cfg_data;

  pose_word_t pose_queue[$];
  velocity_t  velocity_queue[$];
  pose_word_t current_word;
  logic [15:0] model_dead_zone;
  logic [15:0] model_control_zone;
  bit         failed;
  bit         quiet;
  bit         long_hold;
  int         accepted_words;
  int         send_gap;
  int         take_gap;

  goal_velocity_vector u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // integer square root, floor
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // sin(pi/2 x) in q30 by odd taylor polynomial
  function automatic longint unsigned quarter_sine(longint unsigned x);
    longint unsigned x2;
    longint unsigned p;
    x2 = (x * x) >> 30;
    p = 64'd172272;
    p = 64'd5026995 - ((x2 * p) >> 30);
    p = 64'd85569306 - ((x2 * p) >> 30);
    p = 64'd693598668 - ((x2 * p) >> 30);
    p = 64'd1686629713 - ((x2 * p) >> 30);
    return (x * p) >> 30;
  endfunction

  // expected velocity command for one word at the current register values
  function automatic velocity_t predict_velocity(pose_word_t w);
    longint bx;
    longint by;
    longint unsigned ax, ay, m, sq, nx, ny, len, mx, my, lq, t, s, lim, dz, cz;
    bit negx, negy, big, dead;
    velocity_t r;
    bx = longint'(w.goal_x) - longint'(w.pose_x) + longint'(w.offset_x);
    by = longint'(w.goal_y) - longint'(w.pose_y) + longint'(w.offset_y);
    negx = bx < 0;
    negy = by < 0;
    ax = negx ? -bx : bx;
    ay = negy ? -by : by;
    m = (ax > ay) ? ax : ay;
    big = m >= 64'h8000_0000;
    sq = big ? 0 : ax * ax + ay * ay;
    lim = 64'd65536;
    dz = model_dead_zone;
    cz = model_control_zone;
    dead = 0;
    if (!big) begin
      if (sq < dz * dz) dead = 1;
      else if (sq < lim && sq * 10000 < lim) dead = 1;
    end
    r.vel_x = '0;
    r.vel_y = '0;
    r.dead = dead;
    r.ramp = 0;
    if (!dead) begin
      nx = ax;
      ny = ay;
      while (m >= 64'h8000_0000) begin
        nx = nx >> 1; ny = ny >> 1; m = m >> 1;
      end
      while (m < 64'h4000_0000) begin
        nx = nx << 1; ny = ny << 1; m = m << 1;
      end
      len = floor_root(nx * nx + ny * ny);
      mx = ((nx << 14) + (len >> 1)) / len;
      my = ((ny << 14) + (len >> 1)) / len;
      if (mx > 16384) mx = 16384;
      if (my > 16384) my = 16384;
      // sine ramp inside the control zone
      if (!big && cz != 0 && sq < cz * cz) begin
        lq = floor_root(sq << 20);
        t = (lq << 6) / cz;
        if (t > 65536) t = 65536;
        s = quarter_sine(t << 14);
        mx = (mx * s + 64'h2000_0000) >> 30;
        my = (my * s + 64'h2000_0000) >> 30;
        r.ramp = 1;
      end
      r.vel_x = negx ? 16'(-mx) : 16'(mx);
      r.vel_y = negy ? 16'(-my) : 16'(my);
    end
    return r;
  endfunction

  // word with a goal near the robot, so the zones are reached
  function automatic pose_word_t near_word(int reach);
    pose_word_t w;
    w.pose_x   = 16'($urandom);
    w.pose_y   = 16'($urandom);
    w.offset_x = 16'($urandom_range(0, 2 * reach) - reach);
    w.offset_y = 16'($urandom_range(0, 2 * reach) - reach);
    w.goal_x   = w.pose_x + 16'($urandom_range(0, 2 * reach) - reach);
    w.goal_y   = w.pose_y + 16'($urandom_range(0, 2 * reach) - reach);
    return w;
  endfunction

  function automatic pose_word_t make_word(logic [15:0] px, logic [15:0] py,
                                           logic [15:0] gx, logic [15:0] gy,
                                           logic [15:0] ox, logic [15:0] oy);
    pose_word_t w;
    w.pose_x = px; w.pose_y = py; w.goal_x = gx;
    w.goal_y = gy; w.offset_x = ox; w.offset_y = oy;
    return w;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // source side: words from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      s_tdata  <= '0;
      send_gap = 0;
    end else if (s_tvalid && !s_tready) begin
      s_tvalid <= 1;
    end else begin
      if (s_tvalid) begin
        velocity_queue.push_back(predict_velocity(current_word));
        accepted_words <= accepted_words + 1;
      end
      if (!quiet && send_gap == 0 && $urandom_range(0, 5) == 0)
        send_gap = $urandom_range(1, 6);
      if (send_gap > 0 || pose_queue.size() == 0) begin
        if (send_gap > 0) send_gap = send_gap - 1;
        s_tvalid <= 0;
      end else begin
        current_word = pose_queue.pop_front();
        s_tdata <= {current_word.offset_y, current_word.offset_x, current_word.goal_y,
                    current_word.goal_x, current_word.pose_y, current_word.pose_x};
        s_tvalid <= 1;
      end
    end
  end

  // sink side: ready with random stalls, results checked in order
  always @(posedge clk) begin
    velocity_t exp_v;
    if (rst) begin
      m_tready <= 0;
      take_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (velocity_queue.size() == 0) begin
          $error("unexpected word: vel_x %h vel_y %h", m_tdata[15:0], m_tdata[31:16]);
          failed = 1;
        end else begin
          exp_v = velocity_queue.pop_front();
          if (m_tdata[15:0] !== exp_v.vel_x) begin
            $error("vel_x expected %h actual %h", exp_v.vel_x, m_tdata[15:0]);
            failed = 1;
          end
          if (m_tdata[31:16] !== exp_v.vel_y) begin
            $error("vel_y expected %h actual %h", exp_v.vel_y, m_tdata[31:16]);
            failed = 1;
          end
          if (m_tuser[0] !== exp_v.dead) begin
            $error("in_dead_zone expected %b actual %b", exp_v.dead, m_tuser[0]);
            failed = 1;
          end
          if (m_tuser[1] !== exp_v.ramp) begin
            $error("in_ramp_zone expected %b actual %b", exp_v.ramp, m_tuser[1]);
            failed = 1;
          end
        end
      end
      if (!quiet && take_gap == 0 && $urandom_range(0, 5) == 0)
        take_gap = $urandom_range(1, 6);
      if (long_hold) begin
        m_tready <= 0;
      end else if (take_gap > 0) begin
        take_gap = take_gap - 1;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // long output stall once the stream is running, so the pipeline backs up
  initial begin
    long_hold = 0;
    wait (accepted_words >= 150);
    @(posedge clk);
    long_hold <= 1;
    repeat (400) @(posedge clk);
    long_hold <= 0;
  end

  // register write while the block is idle
  task automatic write_reg(gvv_pkg::gvv_reg_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == gvv_pkg::REG_DEAD_ZONE) model_dead_zone = value;
    else model_control_zone = value;
  endtask

  // wait until every result is back and the pipeline has drained
  task automatic drain();
    wait (pose_queue.size() == 0 && !s_tvalid && velocity_queue.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_words(int count, int reach);
    repeat (count) begin
      if ($urandom_range(0, 9) < 6) pose_queue.push_back(near_word(reach));
      else pose_queue.push_back(make_word(16'($urandom), 16'($urandom), 16'($urandom),
                                          16'($urandom), 16'($urandom), 16'($urandom)));
    end
  endtask

  // stimulus and end of run
  initial begin
    rst = 1;
    cfg_valid = 0;
    cfg_index = gvv_pkg::REG_DEAD_ZONE;
    cfg_data = '0;
    failed = 0;
    quiet = 0;
    accepted_words = 0;
    model_dead_zone = 16'd26;
    model_control_zone = 16'd256;
    repeat (12) @(posedge clk);
    rst <= 0;

    // directed words at reset settings
    pose_queue.push_back(make_word(0, 0, 0, 0, 0, 0));
    pose_queue.push_back(make_word(16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                                   16'h7fff, 16'h7fff));
    pose_queue.push_back(make_word(16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                                   16'h8000, 16'h8000));
    pose_queue.push_back(make_word(16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                                   16'h8000, 16'h7fff));
    pose_queue.push_back(make_word(0, 0, 25, 0, 0, 0));
    pose_queue.push_back(make_word(0, 0, 26, 0, 0, 0));
    pose_queue.push_back(make_word(0, 0, 0, -128, 0, 0));
    pose_queue.push_back(make_word(0, 0, 255, 0, 0, 0));
    pose_queue.push_back(make_word(0, 0, 256, 0, 0, 0));
    pose_queue.push_back(make_word(100, -100, 0, 0, 0, 0));
    pose_queue.push_back(make_word(0, 0, 0, 0, 300, -1000));
    drain();

    // tiny distances hit the 1 cm floor only with no dead zone
    write_reg(gvv_pkg::REG_DEAD_ZONE, 16'd0);
    write_reg(gvv_pkg::REG_CONTROL_ZONE, 16'd1);
    pose_queue.push_back(make_word(0, 0, 0, 0, 0, 0));
    pose_queue.push_back(make_word(0, 0, 2, 0, 0, 0));
    pose_queue.push_back(make_word(0, 0, 0, 3, 0, 0));
    pose_queue.push_back(make_word(0, 0, 1, -1, 0, 0));
    pose_queue.push_back(make_word(0, 0, 0, 0, -2, -2));
    pose_queue.push_back(make_word(5, 5, 4, 4, 0, 0));
    random_words(265, 8);
    drain();

    write_reg(gvv_pkg::REG_CONTROL_ZONE, 16'd65535);
    random_words(265, 4000);
    drain();

    write_reg(gvv_pkg::REG_DEAD_ZONE, 16'd65535);
    random_words(265, 32767);
    drain();

    // no ramp at all
    write_reg(gvv_pkg::REG_DEAD_ZONE, 16'($urandom_range(0, 64)));
    write_reg(gvv_pkg::REG_CONTROL_ZONE, 16'd0);
    random_words(265, 300);
    drain();

    write_reg(gvv_pkg::REG_DEAD_ZONE, 16'd13);
    write_reg(gvv_pkg::REG_CONTROL_ZONE, 16'($urandom_range(1, 2000)));
    random_words(265, 1500);
    drain();

    // last part runs with no idling
    write_reg(gvv_pkg::REG_DEAD_ZONE, 16'd26);
    write_reg(gvv_pkg::REG_CONTROL_ZONE, 16'd512);
    quiet = 1;
    random_words(265, 700);
    drain();

    if (velocity_queue.size() != 0) begin
      $error("%0d results never arrived", velocity_queue.size());
      failed = 1;
    end
    if (!failed) begin
      $display("goal_velocity_vector: match");
    end else begin
      $display("goal_velocity_vector: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("goal_velocity_vector: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gvv_pkg.sv
rtl/gvv_front.sv
rtl/gvv_isqrt.sv
rtl/gvv_div.sv
rtl/gvv_sine.sv
rtl/goal_velocity_vector.sv
sim/goal_velocity_vector_test.sv
